FILE: rtl/core/gxtt_pkg.sv
// Shared types and constants of the GX texture tile converter.
package gxtt_pkg;

   // Largest tile row width the address math supports
   localparam int unsigned MAX_WIDTH_TILES = 256;

   localparam int unsigned LANES      = 4;
   localparam int unsigned ADDR_W     = 22;
   localparam int unsigned DATA_W     = 64;
   localparam int unsigned WIDTH_W    = 9;
   localparam int unsigned COL_W      = 8;
   localparam int unsigned ROW_W      = 10;
   localparam int unsigned TILE_W     = 17;
   localparam int unsigned CSR_DATA_W = 9;

   // Register map of the configuration port
   localparam logic CSR_TEXTURE_FORMAT = 1'b0;
   localparam logic CSR_WIDTH_IN_TILES = 1'b1;

   // Offset of the green-blue half of an RGBA8 tile
   localparam logic [ADDR_W-1:0] GB_OFFSET = ADDR_W'(32);

   // Texture format codes; the unused code behaves as opaque RGBA8
   typedef enum logic [1:0] {
      FMT_RGB565       = 2'd0,
      FMT_RGBA8_SRC    = 2'd1,
      FMT_RGBA8_OPAQUE = 2'd2
   } format_type;

   // What one lane produces for one pixel
   typedef struct packed {
      logic [15:0] rgb565;
      logic [15:0] alpha_red;
      logic [15:0] green_blue;
   } lane_word_type;

   // Control that travels with an item into the merge stage
   typedef struct packed {
      logic              valid;
      logic              rgb565_mode;
      logic [TILE_W-1:0] tile;
      logic [1:0]        sub_row;
   } item_ctrl_type;

endpackage

FILE: rtl/core/gxtt_pixel_lane.sv
// One pixel lane: converts a packed ARGB pixel into 565 and RGBA8 byte pairs.
module gxtt_pixel_lane
   import gxtt_pkg::*;
(
   input  logic [31:0]   pixel,
   input  logic          force_alpha,
   output lane_word_type word
);

   logic [7:0] alpha;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   assign alpha = force_alpha ? 8'hff : pixel[31:24];
   assign red   = pixel[23:16];
   assign green = pixel[15:8];
   assign blue  = pixel[7:0];

   // Truncate channels to 5-6-5, keep full bytes for RGBA8
   assign word.rgb565     = {red[7:3], green[7:2], blue[7:3]};
   assign word.alpha_red  = {alpha, red};
   assign word.green_blue = {green, blue};

endmodule

FILE: rtl/core/gxtt_merge.sv
// Merge stage: packs the lane words and forms the write addresses.
module gxtt_merge
   import gxtt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  item_ctrl_type         ctrl,
   input  lane_word_type [LANES-1:0] lane_words,
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_first_address,
   output logic [DATA_W-1:0]     rsp_first_data,
   output logic [ADDR_W-1:0]     rsp_second_address,
   output logic [DATA_W-1:0]     rsp_second_data,
   output logic                  rsp_second_valid
);

   logic [ADDR_W-1:0] tile_addr;
   logic [ADDR_W-1:0] row_addr;
   logic [ADDR_W-1:0] first_addr;
   logic [DATA_W-1:0] pack565;
   logic [DATA_W-1:0] pack_ar;
   logic [DATA_W-1:0] pack_gb;

   logic              valid_ff;
   logic [ADDR_W-1:0] first_address_ff,  first_address_in;
   logic [DATA_W-1:0] first_data_ff,     first_data_in;
   logic [ADDR_W-1:0] second_address_ff, second_address_in;
   logic [DATA_W-1:0] second_data_ff,    second_data_in;
   logic              second_valid_ff,   second_valid_in;

   // Lane 0 is the leftmost pixel and lands in the top bits
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         pack565[DATA_W-1-16*k -: 16] = lane_words[k].rgb565;
         pack_ar[DATA_W-1-16*k -: 16] = lane_words[k].alpha_red;
         pack_gb[DATA_W-1-16*k -: 16] = lane_words[k].green_blue;
      end
   end

   // Tile base: 32 bytes per tile in 565, 64 in RGBA8; rows are 8 bytes
   assign tile_addr = ctrl.rgb565_mode ? ADDR_W'({ctrl.tile, 5'b0})
                                       : ADDR_W'({ctrl.tile, 6'b0});
   assign row_addr  = ADDR_W'({ctrl.sub_row, 3'b0});
   assign first_addr = tile_addr + row_addr;

   always_comb begin
      first_address_in = first_addr;
      if (ctrl.rgb565_mode) begin
         first_data_in     = pack565;
         second_address_in = '0;
         second_data_in    = '0;
         second_valid_in   = 1'b0;
      end else begin
         first_data_in     = pack_ar;
         second_address_in = first_addr + GB_OFFSET;
         second_data_in    = pack_gb;
         second_valid_in   = 1'b1;
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctrl.valid;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      first_address_ff  <= first_address_in;
      first_data_ff     <= first_data_in;
      second_address_ff <= second_address_in;
      second_data_ff    <= second_data_in;
      second_valid_ff   <= second_valid_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_first_address  = first_address_ff;
   assign rsp_first_data     = first_data_ff;
   assign rsp_second_address = second_address_ff;
   assign rsp_second_data    = second_data_ff;
   assign rsp_second_valid   = second_valid_ff;

endmodule

FILE: rtl/core/gx_texture_tile_converter.sv
// Top level of the GX texture tile converter: registers, lanes and pipeline.
//
// Takes one row of four pixels per cycle and returns its tiled texture
// writes through a register stage after the pixel lanes and tile
// multiply and another in the merge stage. busy never rises, so a new
// transaction may start every cycle; the result strobe rsp_valid is one
// cycle wide and the receiver has no way to stall it. Configuration
// registers are written through the csr_ channel, which is always ready;
// change them only while no transaction is in flight.
module gx_texture_tile_converter
   import gxtt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request
   input  logic                  start,
   output logic                  busy,
   input  logic [COL_W-1:0]      req_tile_column,
   input  logic [ROW_W-1:0]      req_pixel_row,
   input  logic [31:0]           req_pixel_0,
   input  logic [31:0]           req_pixel_1,
   input  logic [31:0]           req_pixel_2,
   input  logic [31:0]           req_pixel_3,
   // response
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     rsp_first_address,
   output logic [DATA_W-1:0]     rsp_first_data,
   output logic [ADDR_W-1:0]     rsp_second_address,
   output logic [DATA_W-1:0]     rsp_second_data,
   output logic                  rsp_second_valid,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [1:0]         format_ff;
   logic [WIDTH_W-1:0] width_ff;
   logic [WIDTH_W-1:0] width_eff;
   logic               accept;
   logic               rgb565_mode;
   logic               force_alpha;
   logic [31:0]        pixels [LANES];
   logic [TILE_W-1:0]  tile_in;

   lane_word_type [LANES-1:0] lane_words_in;
   lane_word_type [LANES-1:0] lane_words_ff;
   item_ctrl_type             ctrl_ff, ctrl_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= FMT_RGB565;
         width_ff  <= WIDTH_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TEXTURE_FORMAT: format_ff <= csr_data[1:0];
            CSR_WIDTH_IN_TILES: width_ff  <= csr_data[WIDTH_W-1:0];
            default:            format_ff <= format_ff;
         endcase
      end
   end

   // Width of zero counts as one, large widths saturate
   always_comb begin
      priority if (width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH_TILES)) begin
         width_eff = WIDTH_W'(MAX_WIDTH_TILES);
      end else begin
         width_eff = width_ff;
      end
   end

   assign rgb565_mode = (format_ff == FMT_RGB565);
   assign force_alpha = (format_ff != FMT_RGBA8_SRC);

   // Tile number: tile row times width plus column
   assign tile_in = TILE_W'(req_pixel_row[ROW_W-1:2] * width_eff)
                  + TILE_W'(req_tile_column);

   assign pixels[0] = req_pixel_0;
   assign pixels[1] = req_pixel_1;
   assign pixels[2] = req_pixel_2;
   assign pixels[3] = req_pixel_3;

   // Pixel lanes
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      gxtt_pixel_lane u_lane (
         .pixel       (pixels[k]),
         .force_alpha (force_alpha),
         .word        (lane_words_in[k])
      );
   end

   always_comb begin
      ctrl_in.valid       = accept;
      ctrl_in.rgb565_mode = rgb565_mode;
      ctrl_in.tile        = tile_in;
      ctrl_in.sub_row     = req_pixel_row[1:0];
   end

   // Stage 1 control and payload; only the strobe is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else begin
         ctrl_ff.valid <= ctrl_in.valid;
      end
      ctrl_ff.rgb565_mode <= ctrl_in.rgb565_mode;
      ctrl_ff.tile        <= ctrl_in.tile;
      ctrl_ff.sub_row     <= ctrl_in.sub_row;
      lane_words_ff       <= lane_words_in;
   end

   gxtt_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl_ff),
      .lane_words         (lane_words_ff),
      .rsp_valid          (rsp_valid),
      .rsp_first_address  (rsp_first_address),
      .rsp_first_data     (rsp_first_data),
      .rsp_second_address (rsp_second_address),
      .rsp_second_data    (rsp_second_data),
      .rsp_second_valid   (rsp_second_valid)
   );

endmodule
